// ----- rtl/six_tap_luma_halfpel_filter_assert.svh -----
// Assertion macros shared by the six-tap filter modules.
// Each macro samples on aclk and is disabled while aresetn is low.
`ifndef SIX_TAP_LUMA_HALFPEL_FILTER_ASSERT_SVH
`define SIX_TAP_LUMA_HALFPEL_FILTER_ASSERT_SVH

`define STLHF_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("six-tap filter invariant violated");

`define STLHF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("six-tap filter implication violated");

`define STLHF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("six-tap filter sequence violated");

`endif

// ----- rtl/stlhf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package stlhf_pkg;

    localparam int DEF_BLOCK_WIDTH  = 16;
    localparam int DEF_BLOCK_HEIGHT = 16;

    localparam int PIX_W       = 8;
    localparam int WIN_DEPTH   = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [4:0] TAP_CENTER = 5'd19;
    localparam logic [3:0] ROUND_BIAS = 4'd8;
    localparam int         OUT_SHIFT  = 4;

    // Six taps of one output position plus its row and block markers.
    typedef struct packed {
        logic [PIX_W-1:0] m2;
        logic [PIX_W-1:0] m1;
        logic [PIX_W-1:0] p0;
        logic [PIX_W-1:0] p1;
        logic [PIX_W-1:0] p2;
        logic [PIX_W-1:0] p3;
        logic             row_end;
        logic             block_end;
    } job_t;

endpackage

`default_nettype wire

// ----- rtl/six_tap_luma_halfpel_filter.sv -----
// A result is offered on m_valid after its job has passed the queue and both filter stages.
// Throughput: one source pixel per clock unless stalls fill the two-entry queue; a row of
// BLOCK_WIDTH+5 pixels yields BLOCK_WIDTH results through a two-stage filter pipeline.
// Reset: synchronous, active-low aresetn clears the row and column counters, the queue and the
// pipeline valid bits; the pixel window is not reset and is refilled at each row start.
`timescale 1ns / 1ps
`default_nettype none

module six_tap_luma_halfpel_filter #(
    parameter int BLOCK_WIDTH  = stlhf_pkg::DEF_BLOCK_WIDTH,
    parameter int BLOCK_HEIGHT = stlhf_pkg::DEF_BLOCK_HEIGHT
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [stlhf_pkg::PIX_W-1:0] s_src_pixel,
    input  wire logic                        s_row_begin,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [stlhf_pkg::PIX_W-1:0]      m_out_pixel,
    output logic                             m_row_end,
    output logic                             m_block_end
);
    import stlhf_pkg::*;

    logic job_push;
    job_t job;
    logic q_full;
    logic head_valid;
    job_t head_job;
    logic pop;

    stlhf_front #(
        .BLOCK_WIDTH  (BLOCK_WIDTH),
        .BLOCK_HEIGHT (BLOCK_HEIGHT)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_src_pixel (s_src_pixel),
        .s_row_begin (s_row_begin),
        .q_full      (q_full),
        .job_push    (job_push),
        .job         (job)
    );

    stlhf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (job_push),
        .push_job   (job),
        .full       (q_full),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop)
    );

    stlhf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_valid  (head_valid),
        .head_job    (head_job),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_pixel (m_out_pixel),
        .m_row_end   (m_row_end),
        .m_block_end (m_block_end)
    );

endmodule

`default_nettype wire

// ----- rtl/stlhf_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module stlhf_front #(
    parameter int BLOCK_WIDTH  = stlhf_pkg::DEF_BLOCK_WIDTH,
    parameter int BLOCK_HEIGHT = stlhf_pkg::DEF_BLOCK_HEIGHT
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [stlhf_pkg::PIX_W-1:0] s_src_pixel,
    input  wire logic                       s_row_begin,
    input  wire logic                       q_full,
    output logic                            job_push,
    output stlhf_pkg::job_t                 job
);
    import stlhf_pkg::*;

    `include "six_tap_luma_halfpel_filter_assert.svh"

    localparam int ROW_PIXELS = BLOCK_WIDTH + WIN_DEPTH;
    localparam int COL_W      = $clog2(ROW_PIXELS + 1);
    localparam int ROW_W      = (BLOCK_HEIGHT > 1) ? $clog2(BLOCK_HEIGHT) : 1;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(ROW_PIXELS);
    localparam logic [COL_W-1:0] COL_FILL = COL_W'(WIN_DEPTH);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(BLOCK_HEIGHT - 1);

    logic [PIX_W-1:0] win_reg [0:WIN_DEPTH-1];
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    logic             accept;
    logic [COL_W-1:0] col_eff;
    logic [COL_W-1:0] col_inc;
    logic             live;
    logic             fire;
    logic             rend;
    logic             bend;

    always_comb begin
        s_ready  = !q_full;
        accept   = s_valid && s_ready;
        col_eff  = s_row_begin ? '0 : col_reg;
        live     = col_eff < COL_LAST;
        fire     = live && (col_eff >= COL_FILL);
        col_inc  = col_eff + 1'b1;
        rend     = col_inc == COL_LAST;
        bend     = rend && (row_reg == ROW_LAST);
        col_next = col_reg;
        row_next = row_reg;
        if (accept && live) begin
            col_next = col_inc;
            if (fire && rend) begin
                row_next = bend ? '0 : row_reg + 1'b1;
            end
        end
        job_push      = accept && fire;
        job.m2        = win_reg[0];
        job.m1        = win_reg[1];
        job.p0        = win_reg[2];
        job.p1        = win_reg[3];
        job.p2        = win_reg[4];
        job.p3        = s_src_pixel;
        job.row_end   = rend;
        job.block_end = bend;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // The window has no reset; it is read only after a row has refilled it.
    always_ff @(posedge aclk) begin
        if (accept && live) begin
            for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[WIN_DEPTH-1] <= s_src_pixel;
        end
    end

    `STLHF_ASSERT_ALWAYS(a_col_bound, col_reg <= COL_LAST)
    `STLHF_ASSERT_ALWAYS(a_row_bound, row_reg <= ROW_LAST)
    `STLHF_ASSERT_NEXT(a_row_end_saturates, job_push && job.row_end, col_reg == COL_LAST)

endmodule

`default_nettype wire

// ----- rtl/stlhf_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module stlhf_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire stlhf_pkg::job_t  push_job,
    output logic                  full,
    output logic                  head_valid,
    output stlhf_pkg::job_t       head_job,
    input  wire logic             pop
);
    import stlhf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    job_t             slot_reg [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    always_comb begin
        full        = count_reg == CNT_FULL;
        head_valid  = count_reg != '0;
        head_job    = slot_reg[rd_ptr_reg];
        do_push     = push && !full;
        do_pop      = pop && head_valid;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/stlhf_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module stlhf_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        head_valid,
    input  wire stlhf_pkg::job_t             head_job,
    output logic                             pop,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [stlhf_pkg::PIX_W-1:0]      m_out_pixel,
    output logic                             m_row_end,
    output logic                             m_block_end
);
    import stlhf_pkg::*;

    `include "six_tap_luma_halfpel_filter_assert.svh"

    localparam int PAIR_W = PIX_W + 1;
    localparam int PROD_W = PAIR_W + 5;
    localparam int CTR_W  = PROD_W - 1;
    localparam int SIDE_W = PAIR_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int Q_W    = SUM_W - 1 - OUT_SHIFT;

    localparam logic [PIX_W-1:0] PIX_MAX = '1;

    logic              v1_reg;
    logic [CTR_W-1:0]  ctr_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [PIX_W-1:0]  outer_reg;
    logic              rend1_reg;
    logic              bend1_reg;

    logic              m_valid_reg;
    logic [PIX_W-1:0]  pix_reg;
    logic              rend_reg;
    logic              bend_reg;

    logic              out_en;
    logic              s1_en;
    logic [PAIR_W-1:0] pair_c;
    logic [PAIR_W-1:0] pair_s;
    logic [PAIR_W-1:0] pair_o;
    logic [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0] sum;
    logic [Q_W-1:0]    quot;
    logic [PIX_W-1:0]  clamped;

    always_comb begin
        out_en = !m_valid_reg || m_ready;
        s1_en  = !v1_reg || out_en;
        pop    = head_valid && s1_en;

        pair_c = {1'b0, head_job.p0} + {1'b0, head_job.p1};
        pair_s = {1'b0, head_job.m1} + {1'b0, head_job.p2};
        pair_o = {1'b0, head_job.m2} + {1'b0, head_job.p3};
        prod   = PROD_W'(pair_c) * PROD_W'(TAP_CENTER);

        sum = $signed(SUM_W'(ctr_reg)) - $signed(SUM_W'(side_reg))
            + $signed(SUM_W'(outer_reg)) + $signed(SUM_W'(ROUND_BIAS));
        quot = sum[SUM_W-2:OUT_SHIFT];
        if (sum[SUM_W-1]) begin
            clamped = '0;
        end else if (quot > Q_W'(PIX_MAX)) begin
            clamped = PIX_MAX;
        end else begin
            clamped = quot[PIX_W-1:0];
        end

        m_valid     = m_valid_reg;
        m_out_pixel = pix_reg;
        m_row_end   = rend_reg;
        m_block_end = bend_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s1_en) begin
                v1_reg <= head_valid;
            end
            if (out_en) begin
                m_valid_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            ctr_reg   <= prod[PROD_W-1:1];
            side_reg  <= {pair_s, 1'b0};
            outer_reg <= pair_o[PAIR_W-1:1];
            rend1_reg <= head_job.row_end;
            bend1_reg <= head_job.block_end;
        end
        if (out_en && v1_reg) begin
            pix_reg  <= clamped;
            rend_reg <= rend1_reg;
            bend_reg <= bend1_reg;
        end
    end

    `STLHF_ASSERT_IMP(a_out_from_stage, $rose(m_valid_reg), $past(v1_reg))
    `STLHF_ASSERT_NEXT(a_stage_holds, v1_reg && m_valid_reg && !m_ready, v1_reg)
    `STLHF_ASSERT_IMP(a_block_end_row_end, m_valid_reg && bend_reg, rend_reg)

endmodule

`default_nettype wire

// ----- tb/six_tap_luma_halfpel_filter_tb.sv -----
`timescale 1ns / 1ps

module six_tap_luma_halfpel_filter_tb;

    localparam int BLK_W      = stlhf_pkg::DEF_BLOCK_WIDTH;
    localparam int BLK_H      = stlhf_pkg::DEF_BLOCK_HEIGHT;
    localparam int ROW_PIXELS = BLK_W + 5;

    typedef struct packed {
        logic [stlhf_pkg::PIX_W-1:0] pixel;
        logic                        row_end;
        logic                        block_end;
    } luma_result_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic [stlhf_pkg::PIX_W-1:0] s_src_pixel;
    logic                        s_row_begin;
    logic                        m_valid;
    logic                        m_ready;
    logic [stlhf_pkg::PIX_W-1:0] m_out_pixel;
    logic                        m_row_end;
    logic                        m_block_end;

    luma_result_t                expected_luma[$];
    logic [stlhf_pkg::PIX_W-1:0] tap_window[5];
    int                          col_taken;
    int                          rows_finished;
    int                          fail_count;
    int                          items_sent;
    bit                          smooth_flow;

    six_tap_luma_halfpel_filter #(
        .BLOCK_WIDTH (BLK_W),
        .BLOCK_HEIGHT(BLK_H)
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_src_pixel(s_src_pixel),
        .s_row_begin(s_row_begin),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_pixel(m_out_pixel),
        .m_row_end  (m_row_end),
        .m_block_end(m_block_end)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_pixel(input int mode, input logic [7:0] base);
        int v;
        case (mode)
            0: begin
                return 8'($urandom_range(0, 255));
            end
            1: begin
                return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            end
            default: begin
                v = int'(base) + $urandom_range(0, 6) - 3;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                return 8'(v);
            end
        endcase
    endfunction

    task automatic predict_pixel(input logic [7:0] px, input logic rb);
        int           sum;
        luma_result_t r;
        if (rb) col_taken = 0;
        if (col_taken >= ROW_PIXELS) return;
        if (col_taken >= 5) begin
            sum = ((int'(tap_window[2]) + int'(tap_window[3])) * 19) >>> 1;
            sum = sum - 2 * (int'(tap_window[1]) + int'(tap_window[4]));
            sum = sum + ((int'(tap_window[0]) + int'(px)) >>> 1) + 8;
            if (sum < 0) begin
                r.pixel = 8'd0;
            end else if ((sum >>> 4) > 255) begin
                r.pixel = 8'd255;
            end else begin
                r.pixel = 8'(sum >>> 4);
            end
            r.row_end   = (col_taken + 1 == ROW_PIXELS);
            r.block_end = 1'b0;
            if (r.row_end) begin
                if (rows_finished + 1 >= BLK_H) begin
                    r.block_end   = 1'b1;
                    rows_finished = 0;
                end else begin
                    rows_finished++;
                end
            end
            expected_luma.push_back(r);
        end
        for (int i = 0; i < 4; i++) tap_window[i] = tap_window[i+1];
        tap_window[4] = px;
        col_taken++;
    endtask

    // Results are checked before the input beat of the same edge is predicted.
    always @(posedge aclk) begin
        luma_result_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_luma.size() == 0) begin
                    $error("unexpected result beat: out_pixel %0d row_end %0d block_end %0d",
                           m_out_pixel, m_row_end, m_block_end);
                    fail_count++;
                end else begin
                    e = expected_luma.pop_front();
                    if (m_out_pixel !== e.pixel) begin
                        $error("out_pixel: expected %0d, got %0d", e.pixel, m_out_pixel);
                        fail_count++;
                    end
                    if (m_row_end !== e.row_end) begin
                        $error("row_end: expected %0d, got %0d", e.row_end, m_row_end);
                        fail_count++;
                    end
                    if (m_block_end !== e.block_end) begin
                        $error("block_end: expected %0d, got %0d", e.block_end, m_block_end);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) predict_pixel(s_src_pixel, s_row_begin);
        end
    end

    initial begin
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (smooth_flow) begin
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
            end
        end
    end

    task automatic send_pixel(input logic [7:0] px, input logic rb);
        int gap;
        gap = smooth_flow ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_src_pixel <= px;
        s_row_begin <= rb;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_row(input int len, input bit flagged);
        int         mode;
        logic [7:0] base;
        mode = $urandom_range(0, 2);
        base = 8'($urandom_range(0, 255));
        for (int i = 0; i < len; i++) begin
            send_pixel(pick_pixel(mode, base), flagged && (i == 0));
        end
    endtask

    // An unflagged first row after reset, both clamp limits, extra pixels and an abandoned row.
    task automatic test_directed_edges();
        logic [7:0] row[ROW_PIXELS];
        row = '{8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255,
                8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0,
                8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                8'd0, 8'd0, 8'd128};
        for (int i = 0; i < ROW_PIXELS; i++) send_pixel(row[i], 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd1, 1'b0);
        send_pixel(8'd170, 1'b1);
        send_pixel(8'd85, 1'b0);
        send_pixel(8'd15, 1'b0);
    endtask

    task automatic test_random_rows(input int n_items);
        int goal;
        int r;
        goal = items_sent + n_items;
        while (items_sent < goal) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                send_row(ROW_PIXELS, 1'b1);
            end else if (r < 82) begin
                send_row(ROW_PIXELS, 1'b1);
                send_row($urandom_range(1, 4), 1'b0);
            end else if (r < 88) begin
                send_row($urandom_range(1, ROW_PIXELS - 1), 1'b1);
            end else if (r < 94) begin
                send_row(ROW_PIXELS, 1'b0);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_pixel(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    task automatic test_back_to_back(input int n_items);
        smooth_flow = 1'b1;
        test_random_rows(n_items);
        smooth_flow = 1'b0;
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_src_pixel   = '0;
        s_row_begin   = 1'b0;
        smooth_flow   = 1'b0;
        fail_count    = 0;
        items_sent    = 0;
        col_taken     = 0;
        rows_finished = 0;
        for (int i = 0; i < 5; i++) tap_window[i] = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_edges();
        test_random_rows(600);
        test_back_to_back(350);
        test_random_rows(600);
        s_valid <= 1'b0;

        smooth_flow = 1'b1;
        while (expected_luma.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
